// ===== src/stack_machine_instruction_executor_macros.svh =====
// assertion helpers shared by sme_front and sme_back
`ifndef STACK_MACHINE_INSTRUCTION_EXECUTOR_MACROS_SVH
`define STACK_MACHINE_INSTRUCTION_EXECUTOR_MACROS_SVH

// check that is off while reset is asserted
`define SME_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// check that also holds during reset
`define SME_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/sme_pkg.sv =====
package sme_pkg;

    localparam int STACK_WORDS_DEF   = 1024;
    localparam int PROGRAM_WORDS_DEF = 1024;

    // opcodes
    localparam logic [3:0] OP_NOP   = 4'd0;
    localparam logic [3:0] OP_PUSH  = 4'd1;
    localparam logic [3:0] OP_ADD   = 4'd2;
    localparam logic [3:0] OP_SUB   = 4'd3;
    localparam logic [3:0] OP_MUL   = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_JMP   = 4'd6;
    localparam logic [3:0] OP_HALT  = 4'd7;
    localparam logic [3:0] OP_EQ    = 4'd8;
    localparam logic [3:0] OP_JNZ   = 4'd9;
    localparam logic [3:0] OP_JZ    = 4'd10;
    localparam logic [3:0] OP_DUP   = 4'd11;
    localparam logic [3:0] OP_PRINT = 4'd12;

    // trap codes
    localparam logic [2:0] TRAP_OK        = 3'd0;
    localparam logic [2:0] TRAP_OVERFLOW  = 3'd1;
    localparam logic [2:0] TRAP_UNDERFLOW = 3'd2;
    localparam logic [2:0] TRAP_DIVZERO   = 3'd3;
    localparam logic [2:0] TRAP_ILLEGAL   = 3'd4;
    localparam logic [2:0] TRAP_BADFETCH  = 3'd5;
    localparam logic [2:0] TRAP_BADARG    = 3'd6;

    // instruction class set by the front end
    typedef enum logic [3:0] {
        C_NOP, C_PUSH, C_ALU, C_JMP, C_HALT, C_BR, C_DUP, C_PRINT, C_ILL
    } t_cls;

    typedef struct packed {
        t_cls        cls;
        logic [3:0]  op;
        logic [63:0] arg;
    } t_instr;

    // front to back queue head
    typedef struct packed {
        logic   valid;
        t_instr instr;
    } t_link;

    typedef struct packed {
        logic [2:0]  trap_code;
        logic [63:0] next_pointer;
        logic        halted;
        logic        print_valid;
        logic [63:0] print_value;
        logic [10:0] stack_depth;
    } t_result;

    function automatic t_cls classify(input logic [3:0] op);
        t_cls c;
        case (op)
            OP_NOP:   c = C_NOP;
            OP_PUSH:  c = C_PUSH;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ: c = C_ALU;
            OP_JMP:   c = C_JMP;
            OP_HALT:  c = C_HALT;
            OP_JNZ, OP_JZ: c = C_BR;
            OP_DUP:   c = C_DUP;
            OP_PRINT: c = C_PRINT;
            default:  c = C_ILL;
        endcase
        return c;
    endfunction

endpackage

// ===== src/sme_ram.sv =====
module sme_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/sme_front.sv =====
module sme_front import sme_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [3:0]  i_opcode,
    input  logic [63:0] i_operand,
    output t_link       o_link,
    input  logic        i_take
);
    `include "stack_machine_instruction_executor_macros.svh"

    t_instr     r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign full   = (r_cnt == 2'd2);
    assign wr     = push && !full;
    assign rd     = i_take && (r_cnt != 2'd0);
    assign o_link = '{valid: (r_cnt != 2'd0), instr: r_buf[r_rp]};

    // classify on entry and queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_buf[r_wp] <= '{cls: classify(i_opcode), op: i_opcode, arg: i_operand};
                r_wp        <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    `SME_ASSERT(a_cnt_max, i_clk, i_rst_n, r_cnt != 2'd3, "queue count out of range")
    `SME_ASSERT(a_no_take_empty, i_clk, i_rst_n, (r_cnt == 2'd0 && !wr) |=> (r_cnt == 2'd0), "queue count moved while idle")
    `SME_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> (r_cnt == 2'd0), "queue not empty after reset")
endmodule

// ===== src/sme_back.sv =====
module sme_back import sme_pkg::*; #(
    parameter int STACK_WORDS   = STACK_WORDS_DEF,
    parameter int PROGRAM_WORDS = PROGRAM_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_link       i_link,
    output logic        o_take,
    input  logic [10:0] i_plen,
    input  logic        pop,
    output logic        empty,
    output t_result     o_res
);
    `include "stack_machine_instruction_executor_macros.svh"

    localparam int AW = $clog2(STACK_WORDS);
    localparam int DW = $clog2(STACK_WORDS + 1);

    typedef enum logic [2:0] {S_IDLE, S_RD1, S_RD2, S_MUL, S_DIV, S_FIX} t_state;

    t_state      r_state, n_state;
    t_instr      r_ins, n_ins;
    logic [DW-1:0] r_depth, n_depth;
    logic [63:0] r_ip, n_ip;
    logic        r_halt, n_halt;
    logic [63:0] r_a, n_a, r_b, n_b, r_acc, n_acc, r_rem, n_rem, r_quo, n_quo;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;
    logic        r_out_valid, n_out_valid;
    t_result     r_out, n_out;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   wdata, rdata;
    logic          fin;
    logic [2:0]    f_trap;
    logic          f_pv;
    logic [63:0]   f_pval;
    logic [63:0]   d64, lim64, arg, res;
    logic [31:0]   mx, my;
    logic [63:0]   prod;
    logic [64:0]   rem_sh;
    logic          full_stk;

    sme_ram #(.WIDTH(64), .DEPTH(STACK_WORDS)) u_stack (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign d64      = 64'(r_depth);
    assign full_stk = d64 >= 64'(STACK_WORDS);
    assign lim64    = (64'(i_plen) > 64'(PROGRAM_WORDS)) ? 64'(PROGRAM_WORDS) : 64'(i_plen);
    assign arg      = r_ins.arg;
    assign empty    = !r_out_valid;
    assign o_res    = r_out;

    // shared 32x32 multiplier for the partial products
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    begin mx = r_a[31:0];  my = r_b[31:0];  end
            2'd1:    begin mx = r_a[31:0];  my = r_b[63:32]; end
            default: begin mx = r_a[63:32]; my = r_b[31:0];  end
        endcase
        prod   = 64'(mx) * 64'(my);
        rem_sh = {r_rem, r_quo[63]};
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_ins = r_ins; n_depth = r_depth; n_ip = r_ip; n_halt = r_halt;
        n_a = r_a; n_b = r_b; n_acc = r_acc; n_rem = r_rem; n_quo = r_quo;
        n_cnt = r_cnt; n_neg = r_neg;
        n_out_valid = r_out_valid && !pop;
        n_out = r_out;
        we = 1'b0; waddr = AW'(d64); wdata = 64'd0; raddr = '0;
        o_take = 1'b0; fin = 1'b0; f_trap = TRAP_OK; f_pv = 1'b0; f_pval = 64'd0;
        res = 64'd0;
        case (r_state)
            S_IDLE: begin
                if (i_link.valid && (!r_out_valid || pop)) begin
                    o_take = 1'b1;
                    n_ins  = i_link.instr;
                    fin    = 1'b1;
                    if (r_halt) begin
                        fin = 1'b1;
                    end else if (r_ip[63] || r_ip >= lim64) begin
                        f_trap = TRAP_BADFETCH;
                    end else begin
                        case (i_link.instr.cls)
                            C_NOP: n_ip = r_ip + 64'd1;
                            C_PUSH: begin
                                if (full_stk) begin
                                    f_trap = TRAP_OVERFLOW;
                                end else begin
                                    we = 1'b1; wdata = i_link.instr.arg;
                                    n_depth = DW'(r_depth + DW'(1)); n_ip = r_ip + 64'd1;
                                end
                            end
                            C_ALU: begin
                                if (d64 < 64'd2) begin
                                    f_trap = TRAP_UNDERFLOW;
                                end else begin
                                    fin = 1'b0; raddr = AW'(d64 - 64'd2); n_state = S_RD1;
                                end
                            end
                            C_JMP:  n_ip = i_link.instr.arg;
                            C_HALT: n_halt = 1'b1;
                            C_BR, C_PRINT: begin
                                if (d64 < 64'd1) begin
                                    f_trap = TRAP_UNDERFLOW;
                                end else begin
                                    fin = 1'b0; raddr = AW'(d64 - 64'd1); n_state = S_RD1;
                                end
                            end
                            C_DUP: begin
                                if (full_stk) begin
                                    f_trap = TRAP_OVERFLOW;
                                end else if (i_link.instr.arg[63]) begin
                                    f_trap = TRAP_BADARG;
                                end else if (i_link.instr.arg >= d64) begin
                                    f_trap = TRAP_UNDERFLOW;
                                end else begin
                                    fin = 1'b0;
                                    raddr = AW'(d64 - 64'd1 - i_link.instr.arg);
                                    n_state = S_RD1;
                                end
                            end
                            default: f_trap = TRAP_ILLEGAL;
                        endcase
                    end
                end
            end
            S_RD1: begin
                n_state = S_IDLE;
                fin     = 1'b1;
                case (r_ins.cls)
                    C_ALU: begin
                        fin = 1'b0; n_a = rdata; raddr = AW'(d64 - 64'd1); n_state = S_RD2;
                    end
                    C_BR: begin
                        n_depth = DW'(r_depth - DW'(1));
                        if ((rdata != 64'd0) == (r_ins.op == OP_JNZ)) n_ip = arg;
                        else n_ip = r_ip + 64'd1;
                    end
                    C_PRINT: begin
                        f_pv = 1'b1; f_pval = rdata;
                        n_depth = DW'(r_depth - DW'(1)); n_ip = r_ip + 64'd1;
                    end
                    C_DUP: begin
                        we = 1'b1; wdata = rdata;
                        n_depth = DW'(r_depth + DW'(1)); n_ip = r_ip + 64'd1;
                    end
                    default: fin = 1'b1;
                endcase
            end
            S_RD2: begin
                n_b = rdata;
                n_cnt = 6'd0;
                case (r_ins.op)
                    OP_MUL: n_state = S_MUL;
                    OP_DIV: begin
                        if (rdata == 64'd0) begin
                            f_trap = TRAP_DIVZERO; fin = 1'b1; n_state = S_IDLE;
                        end else begin
                            n_rem = 64'd0;
                            n_quo = r_a[63] ? 64'd0 - r_a : r_a;
                            n_b   = rdata[63] ? 64'd0 - rdata : rdata;
                            n_neg = r_a[63] ^ rdata[63];
                            n_state = S_DIV;
                        end
                    end
                    default: begin
                        case (r_ins.op)
                            OP_ADD:  res = r_a + rdata;
                            OP_SUB:  res = r_a - rdata;
                            default: res = {63'd0, r_a == rdata};
                        endcase
                        we = 1'b1; waddr = AW'(d64 - 64'd2); wdata = res;
                        n_depth = DW'(r_depth - DW'(1)); n_ip = r_ip + 64'd1;
                        fin = 1'b1; n_state = S_IDLE;
                    end
                endcase
            end
            S_MUL: begin
                if (r_cnt == 6'd0) n_acc = prod;
                else n_acc = r_acc + {prod[31:0], 32'd0};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd2) n_state = S_FIX;
            end
            S_DIV: begin
                if (rem_sh >= {1'b0, r_b}) begin
                    n_rem = 64'(rem_sh - {1'b0, r_b});
                    n_quo = {r_quo[62:0], 1'b1};
                end else begin
                    n_rem = rem_sh[63:0];
                    n_quo = {r_quo[62:0], 1'b0};
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) n_state = S_FIX;
            end
            S_FIX: begin
                if (r_ins.op == OP_DIV) wdata = r_neg ? 64'd0 - r_quo : r_quo;
                else wdata = r_acc;
                we = 1'b1; waddr = AW'(d64 - 64'd2);
                n_depth = DW'(r_depth - DW'(1)); n_ip = r_ip + 64'd1;
                fin = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (fin) begin
            if (f_trap != TRAP_OK) begin
                n_depth = r_depth; n_ip = r_ip; n_halt = r_halt; we = 1'b0;
            end
            n_out_valid       = 1'b1;
            n_out.trap_code   = f_trap;
            n_out.next_pointer = n_ip;
            n_out.halted      = n_halt;
            n_out.print_valid = f_pv;
            n_out.print_value = f_pval;
            n_out.stack_depth = 11'(64'(n_depth));
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_ip        <= 64'd0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_ip        <= n_ip;
            r_halt      <= n_halt;
            r_out_valid <= n_out_valid;
        end
        r_ins <= n_ins; r_a <= n_a; r_b <= n_b; r_acc <= n_acc;
        r_rem <= n_rem; r_quo <= n_quo; r_cnt <= n_cnt; r_neg <= n_neg;
        r_out <= n_out;
    end

    `SME_ASSERT(a_halt_sticks, i_clk, i_rst_n, r_halt |=> r_halt, "halt flag cleared")
    `SME_ASSERT(a_depth_cap, i_clk, i_rst_n, 64'(r_depth) <= 64'(STACK_WORDS), "stack depth past capacity")
    `SME_ASSERT(a_trap_no_print, i_clk, i_rst_n, (r_out_valid && r_out.trap_code != TRAP_OK) |-> !r_out.print_valid, "print reported on a trap")
    `SME_ASSERT(a_busy_no_result, i_clk, i_rst_n, (r_state != S_IDLE) |-> !r_out_valid, "result pending while executing")
endmodule

// ===== src/stack_machine_instruction_executor.sv =====
// stack machine instruction executor
// input queue: present opcode/operand with push; the item is taken when push is
// high and full is low. the instruction must be the one fetched at the last
// reported next_pointer (zero after reset).
// result queue: one result per item; the oldest is on the o_ ports while empty
// is low and is taken with pop.
// configuration: i_cfg_we writes program_length from i_cfg_wdata; write only
// while the block is idle.
// nop, push, jumps, halt and early traps finish in S_IDLE; branches, dup and
// print also pass S_RD1; add, sub, eq and divide by zero read operands in S_RD1
// and S_RD2; multiply then makes three passes through one 32x32 multiplier
// (S_MUL) before S_FIX, and divide runs a bit-serial divider, one quotient bit
// a cycle (S_DIV), before S_FIX. the stack is a single memory with one read and
// one write port, so binary ops read their operands one at a time. the executor
// takes the next item in the cycle its result leaves.
// a two-entry front queue takes new items while the executor works or while a
// result waits; when pop stays low the executor holds after one result and the
// front queue fills, then full goes high.
// reset (synchronous, active low) clears pointer, depth, halt flag, program
// length and both queues; stack memory contents are not cleared.
module stack_machine_instruction_executor import sme_pkg::*; #(
    parameter int STACK_WORDS   = STACK_WORDS_DEF,
    parameter int PROGRAM_WORDS = PROGRAM_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [3:0]  i_opcode,
    input  logic [63:0] i_operand,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_trap_code,
    output logic [63:0] o_next_pointer,
    output logic        o_halted,
    output logic        o_print_valid,
    output logic [63:0] o_print_value,
    output logic [10:0] o_stack_depth,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata
);
    logic [10:0] r_plen;
    t_link       link;
    logic        take;
    t_result     res;

    // program length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= 11'd0;
        end else if (i_cfg_we) begin
            r_plen <= i_cfg_wdata;
        end
    end

    sme_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_opcode(i_opcode), .i_operand(i_operand), .o_link(link), .i_take(take)
    );

    sme_back #(.STACK_WORDS(STACK_WORDS), .PROGRAM_WORDS(PROGRAM_WORDS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_link(link), .o_take(take),
        .i_plen(r_plen), .pop(pop), .empty(empty), .o_res(res)
    );

    assign o_trap_code    = res.trap_code;
    assign o_next_pointer = res.next_pointer;
    assign o_halted       = res.halted;
    assign o_print_valid  = res.print_valid;
    assign o_print_value  = res.print_value;
    assign o_stack_depth  = res.stack_depth;
endmodule

// ===== test/stack_machine_instruction_executor_test.sv =====
`timescale 1ns / 1ps

module stack_machine_instruction_executor_test;
    import sme_pkg::*;

    localparam int          STACK_DEPTH  = 1024;
    localparam int          CODE_WORDS   = 1024;
    localparam int          GEN          = 0;
    localparam int          MODEL        = 1;
    localparam logic [3:0]  OP_BAD_FIRST = 4'd13;
    localparam logic [3:0]  OP_BAD_LAST  = 4'd15;
    localparam logic [63:0] WORD_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] WORD_MAX     = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] WORD_ONES    = 64'hffff_ffff_ffff_ffff;
    localparam int          SETTLE_WAIT  = 100;

    typedef struct packed {
        logic [3:0]  op;
        logic [63:0] arg;
    } t_instr_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [3:0]  i_opcode;
    logic [63:0] i_operand;
    logic        empty;
    logic        pop;
    logic [2:0]  o_trap_code;
    logic [63:0] o_next_pointer;
    logic        o_halted;
    logic        o_print_valid;
    logic [63:0] o_print_value;
    logic [10:0] o_stack_depth;
    logic        i_cfg_we;
    logic [10:0] i_cfg_wdata;

    // two copies of the machine: one shapes the stimulus, one predicts results
    logic [63:0] word_mem [2][STACK_DEPTH];
    int          depth_q [2];
    logic [63:0] ip_q [2];
    logic        halt_q [2];
    int          plen_q [2];

    t_instr_item pending_instrs [$];
    t_result     expected_steps [$];
    int          mismatch_count;
    int          hold_left;
    bit          no_idle;

    stack_machine_instruction_executor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_opcode       (i_opcode),
        .i_operand      (i_operand),
        .empty          (empty),
        .pop            (pop),
        .o_trap_code    (o_trap_code),
        .o_next_pointer (o_next_pointer),
        .o_halted       (o_halted),
        .o_print_valid  (o_print_valid),
        .o_print_value  (o_print_value),
        .o_stack_depth  (o_stack_depth),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // executes one instruction on machine copy who
    function automatic t_result exec_instr(input int who, input logic [3:0] op,
                                           input logic [63:0] arg);
        t_result     r;
        int          eff;
        int          d;
        logic [63:0] ip;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] res;
        logic [2:0]  trap;
        logic        pv;
        logic [63:0] pval;
        eff = plen_q[who] > CODE_WORDS ? CODE_WORDS : plen_q[who];
        d = depth_q[who];
        ip = ip_q[who];
        trap = TRAP_OK;
        pv = 1'b0;
        pval = '0;
        res = '0;
        if (!halt_q[who]) begin
            if (ip[63] || ip >= 64'(eff)) begin
                trap = TRAP_BADFETCH;
            end else begin
                case (op)
                    OP_NOP: ip = ip + 1;
                    OP_PUSH: begin
                        if (d >= STACK_DEPTH) begin
                            trap = TRAP_OVERFLOW;
                        end else begin
                            word_mem[who][d] = arg;
                            d++;
                            ip = ip + 1;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ: begin
                        if (d < 2) begin
                            trap = TRAP_UNDERFLOW;
                        end else begin
                            a = word_mem[who][d-2];
                            b = word_mem[who][d-1];
                            case (op)
                                OP_ADD: res = a + b;
                                OP_SUB: res = a - b;
                                OP_MUL: res = a * b;
                                OP_EQ:  res = {63'b0, a == b};
                                default: begin
                                    if (b == '0) trap = TRAP_DIVZERO;
                                    else if (a == WORD_MIN && b == WORD_ONES) res = a;
                                    else res = $signed(a) / $signed(b);
                                end
                            endcase
                            if (trap == TRAP_OK) begin
                                word_mem[who][d-2] = res;
                                d--;
                                ip = ip + 1;
                            end
                        end
                    end
                    OP_JMP: ip = arg;
                    OP_HALT: halt_q[who] = 1'b1;
                    OP_JNZ, OP_JZ: begin
                        if (d < 1) begin
                            trap = TRAP_UNDERFLOW;
                        end else begin
                            d--;
                            if ((word_mem[who][d] != '0) == (op == OP_JNZ)) ip = arg;
                            else ip = ip + 1;
                        end
                    end
                    OP_DUP: begin
                        if (d >= STACK_DEPTH) trap = TRAP_OVERFLOW;
                        else if (arg[63]) trap = TRAP_BADARG;
                        else if (arg >= 64'(d)) trap = TRAP_UNDERFLOW;
                        else begin
                            word_mem[who][d] = word_mem[who][d - 1 - int'(arg)];
                            d++;
                            ip = ip + 1;
                        end
                    end
                    OP_PRINT: begin
                        if (d < 1) begin
                            trap = TRAP_UNDERFLOW;
                        end else begin
                            d--;
                            pv = 1'b1;
                            pval = word_mem[who][d];
                            ip = ip + 1;
                        end
                    end
                    default: trap = TRAP_ILLEGAL;
                endcase
                if (trap == TRAP_OK) begin
                    depth_q[who] = d;
                    ip_q[who] = ip;
                end
            end
        end
        r.trap_code = trap;
        r.next_pointer = ip_q[who];
        r.halted = halt_q[who];
        r.print_valid = pv;
        r.print_value = pv ? pval : '0;
        r.stack_depth = depth_q[who][10:0];
        return r;
    endfunction

    // queue one instruction, jumping back first when the pointer would run off the end
    task automatic emit(input logic [3:0] op, input logic [63:0] arg);
        t_result     dummy;
        t_instr_item it;
        int          eff;
        eff = plen_q[GEN] > CODE_WORDS ? CODE_WORDS : plen_q[GEN];
        if (eff > 1 && !halt_q[GEN] && ip_q[GEN] == 64'(eff - 1)
                && op != OP_JMP && op != OP_HALT) begin
            it.op = OP_JMP;
            it.arg = 64'($urandom_range(0, eff - 2));
            dummy = exec_instr(GEN, it.op, it.arg);
            pending_instrs.push_back(it);
        end
        it.op = op;
        it.arg = arg;
        dummy = exec_instr(GEN, op, arg);
        pending_instrs.push_back(it);
    endtask

    // wait until the block has drained everything
    task automatic settle();
        while (pending_instrs.size() != 0 || expected_steps.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_plen(input int v);
        settle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 11'(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        plen_q[GEN] = v;
        plen_q[MODEL] = v;
    endtask

    // mostly well-formed code with random values, some noise
    task automatic run_random(input int n);
        int          r;
        int          d;
        int          eff;
        logic [63:0] val;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            d = depth_q[GEN];
            eff = plen_q[GEN] > CODE_WORDS ? CODE_WORDS : plen_q[GEN];
            if ($urandom_range(0, 3) == 0) val = {$urandom, $urandom};
            else val = 64'($signed($urandom_range(0, 20)) - 10);
            if (d > 60 && r < 40) r = r + 40;
            if ((d < 2 && r >= 30 && r < 85) || r < 30) begin
                emit(OP_PUSH, val);
            end else if (r < 45) begin
                case ($urandom_range(0, 4))
                    0: emit(OP_ADD, val);
                    1: emit(OP_SUB, val);
                    2: emit(OP_MUL, val);
                    3: emit(OP_DIV, val);
                    default: emit(OP_EQ, val);
                endcase
            end else if (r < 55) begin
                emit(OP_DUP, 64'($urandom_range(0, d - 1)));
            end else if (r < 65) begin
                emit(OP_PRINT, val);
            end else if (r < 75) begin
                emit($urandom_range(0, 1) ? OP_JNZ : OP_JZ, 64'($urandom_range(0, eff - 1)));
            end else if (r < 80) begin
                emit(OP_JMP, 64'($urandom_range(0, eff - 1)));
            end else if (r < 85) begin
                emit(OP_NOP, val);
            end else if (r < 90) begin
                emit(4'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST)), val);
            end else if (r < 95) begin
                // broken dup: negative or too deep offset
                emit(OP_DUP, $urandom_range(0, 1) ? {1'b1, 63'($urandom)} : 64'(d + $urandom_range(0, 3)));
            end else begin
                emit(OP_PUSH, val);
            end
        end
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // sender: items change on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && pending_instrs.size() != 0
                && (no_idle || $urandom_range(0, 99) >= 15)) begin
            push <= 1'b1;
            i_opcode <= pending_instrs[0].op;
            i_operand <= pending_instrs[0].arg;
        end else begin
            push <= 1'b0;
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
        end else begin
            pop <= i_rst_n && (no_idle || $urandom_range(0, 99) >= 15);
        end
    end

    // check results and predict each accepted item
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_steps.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: trap %0d ptr %h", o_trap_code,
                                 o_next_pointer);
                end else begin
                    e = expected_steps.pop_front();
                    if (o_trap_code !== e.trap_code || o_next_pointer !== e.next_pointer
                            || o_halted !== e.halted || o_print_valid !== e.print_valid
                            || o_print_value !== e.print_value
                            || o_stack_depth !== e.stack_depth) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp trap %0d ptr %h halt %b pv %b val %h dep %0d",
                                     e.trap_code, e.next_pointer, e.halted, e.print_valid,
                                     e.print_value, e.stack_depth, " | got trap %0d ptr %h ",
                                     o_trap_code, o_next_pointer, "halt %b pv %b val %h dep %0d",
                                     o_halted, o_print_valid, o_print_value, o_stack_depth);
                    end
                end
            end
            if (push && !full) begin
                expected_steps.push_back(exec_instr(MODEL, i_opcode, i_operand));
                void'(pending_instrs.pop_front());
            end
        end
    end

    // run limit
    initial begin
        #40ms;
        $display("stack_machine_instruction_executor_test failed");
        $finish;
    end

    // stimulus
    initial begin
        push = 1'b0;
        pop = 1'b0;
        i_opcode = OP_NOP;
        i_operand = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        mismatch_count = 0;
        hold_left = 0;
        no_idle = 1'b0;
        for (int w = 0; w < 2; w++) begin
            depth_q[w] = 0;
            ip_q[w] = '0;
            halt_q[w] = 1'b0;
            plen_q[w] = 0;
        end
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty program: every fetch is out of range
        emit(OP_NOP, '0);
        emit(OP_PUSH, 64'd5);
        write_plen(0);

        // one-word program, then the pointer runs past the end
        write_plen(1);
        emit(OP_JMP, '0);
        emit(OP_PUSH, 64'd7);
        emit(OP_NOP, '0);

        // length above capacity acts as full capacity
        write_plen(2047);
        emit(OP_ADD, '0);
        emit(OP_PRINT, '0);
        emit(OP_PRINT, '0);
        emit(OP_JZ, 64'd3);
        emit(OP_PUSH, WORD_MAX);
        emit(OP_PUSH, WORD_MIN);
        emit(OP_PUSH, WORD_ONES);
        emit(OP_PUSH, '0);
        emit(OP_DUP, WORD_ONES);
        emit(OP_DUP, 64'd4);
        emit(OP_DUP, 64'd3);
        emit(OP_EQ, '0);
        emit(OP_DIV, '0);
        emit(OP_SUB, '0);
        emit(OP_DIV, '0);
        emit(OP_MUL, '0);
        emit(OP_PUSH, 64'd7);
        emit(OP_PUSH, 64'hffff_ffff_ffff_fffd);
        emit(OP_DIV, '0);
        emit(OP_JNZ, 64'd10);
        emit(OP_PUSH, '0);
        emit(OP_JNZ, 64'd30);
        for (int k = OP_BAD_FIRST; k <= OP_BAD_LAST; k++) emit(4'(k), WORD_ONES);
        run_random(130);

        // short program with a long receiver hold-off so the input stalls
        write_plen($urandom_range(4, 20));
        hold_left = 300;
        run_random(130);

        // long stretch with no idling on either side
        write_plen(CODE_WORDS);
        no_idle = 1'b1;
        run_random(100);
        settle();
        no_idle = 1'b0;

        // halt, then everything is ignored
        emit(OP_HALT, '0);
        emit(OP_PUSH, 64'd1);
        emit(OP_PRINT, '0);
        emit(OP_BAD_LAST, '0);
        emit(OP_JMP, WORD_MIN);
        settle();

        if (mismatch_count == 0 && expected_steps.size() == 0)
            $display("stack_machine_instruction_executor_test passed");
        else
            $display("stack_machine_instruction_executor_test failed");
        $finish;
    end

endmodule
